FILE: sv/rclp_pkg.sv
// ----------------------------------------------------------------------------
// rclp_pkg
// Shared constants, phase codes and match tables of the command line parser.
// ----------------------------------------------------------------------------
package rclp_pkg;

	localparam int LINE_MAX   = 128;
	localparam int LINE_CNT_W = $clog2(LINE_MAX);
	localparam logic [LINE_CNT_W-1:0] LINE_LIMIT = LINE_CNT_W'(LINE_MAX - 1);

	localparam int PHASE_W = 4;

	localparam logic [PHASE_W-1:0] PH_START     = 4'd0;
	localparam logic [PHASE_W-1:0] PH_LEAD_CR   = 4'd1;
	localparam logic [PHASE_W-1:0] PH_PING      = 4'd2;
	localparam logic [PHASE_W-1:0] PH_PING_OK   = 4'd3;
	localparam logic [PHASE_W-1:0] PH_HELLO     = 4'd4;
	localparam logic [PHASE_W-1:0] PH_HELLO_OK  = 4'd5;
	localparam logic [PHASE_W-1:0] PH_RATE_KW   = 4'd6;
	localparam logic [PHASE_W-1:0] PH_SRC_WS    = 4'd7;
	localparam logic [PHASE_W-1:0] PH_SRC_WORD  = 4'd8;
	localparam logic [PHASE_W-1:0] PH_NUM_WS    = 4'd9;
	localparam logic [PHASE_W-1:0] PH_NUM       = 4'd10;
	localparam logic [PHASE_W-1:0] PH_DONE      = 4'd11;
	localparam logic [PHASE_W-1:0] PH_BAD       = 4'd12;
	localparam logic [PHASE_W-1:0] PH_END_NONE  = 4'd13;
	localparam logic [PHASE_W-1:0] PH_END_PING  = 4'd14;
	localparam logic [PHASE_W-1:0] PH_END_HELLO = 4'd15;

	localparam logic [2:0] VERDICT_RATE    = 3'd0;
	localparam logic [2:0] VERDICT_PING    = 3'd1;
	localparam logic [2:0] VERDICT_HELLO   = 3'd2;
	localparam logic [2:0] VERDICT_INVALID = 3'd3;
	localparam logic [2:0] VERDICT_OVERRUN = 3'd4;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_H     = 8'h68;
	localparam logic [7:0] CH_R     = 8'h72;

	localparam logic [31:0] PCT_MAX  = 32'd100;
	localparam logic [31:0] SECS_MAX = 32'hffff_ffff;

	// Table lookups return NUL past the end; NUL never reaches the matcher.
	function automatic logic [7:0] ping_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0: c = 8'h70;
			3'd1: c = 8'h69;
			3'd2: c = 8'h6e;
			3'd3: c = 8'h67;
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] hello_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0: c = 8'h68;
			3'd1: c = 8'h65;
			3'd2: c = 8'h6c;
			3'd3: c = 8'h6c;
			3'd4: c = 8'h6f;
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] rate_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0: c = 8'h72;
			3'd1: c = 8'h61;
			3'd2: c = 8'h74;
			3'd3: c = 8'h65;
			3'd4: c = CH_SPACE;
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

	// First source word, five letters
	function automatic logic [7:0] src_a_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0: c = 8'h63;
			3'd1: c = 8'h6f;
			3'd2: c = 8'h64;
			3'd3: c = 8'h65;
			3'd4: c = 8'h78;
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

	// Second source word, six letters
	function automatic logic [7:0] src_b_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0: c = 8'h63;
			3'd1: c = 8'h6c;
			3'd2: c = 8'h61;
			3'd3: c = 8'h75;
			3'd4: c = 8'h64;
			3'd5: c = 8'h65;
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

endpackage

FILE: sv/rate_command_line_parser_core.sv
// ----------------------------------------------------------------------------
// rate_command_line_parser_core
// Byte-wise parser of newline-ended command lines, one verdict per non-blank line.
// ----------------------------------------------------------------------------
// At most one received byte is taken per clock. Each accepted byte updates the
// line state; a newline that ends a non-blank or overrun line loads the result
// register and the verdict is offered on the next cycle. rx_ready is high whenever
// the result register is empty or being taken in the same cycle, so bytes stream
// at one per cycle as long as results are drained. The path that sets the
// clock is the times-ten accumulate and range compare of the number fields.
module rate_command_line_parser_core
	import rclp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_ready,
	input  logic [7:0]  rx_byte,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [2:0]  verdict,
	output logic        source,
	output logic [6:0]  pct_5h,
	output logic [6:0]  pct_week,
	output logic [31:0] secs_5h,
	output logic [31:0] secs_week
);

	logic [LINE_CNT_W-1:0] count_q, count_d;
	logic                  ovr_q, ovr_d;
	logic [PHASE_W-1:0]    phase_q, phase_d;
	logic [2:0]            idx_q, idx_d;
	logic [1:0]            guess_q, guess_d;
	logic [31:0]           acc_q, acc_d;
	logic [6:0]            p0_q, p0_d, p1_q, p1_d;
	logic [31:0]           s0_q, s0_d, s1_q, s1_d;

	logic                  res_valid_q;
	logic [2:0]            verdict_q;
	logic                  source_q;
	logic [6:0]            pct_5h_q, pct_week_q;
	logic [31:0]           secs_5h_q, secs_week_q;

	logic                  accept;
	logic                  res_load;
	logic [2:0]            res_verdict;
	logic                  res_source;
	logic [6:0]            res_p0, res_p1;
	logic [31:0]           res_s0, res_s1;

	logic                  is_blank, is_trim, is_digit;
	logic [35:0]           acc_x10;
	logic [31:0]           field_max;
	logic [1:0]            wc_guess;
	logic [PHASE_W-1:0]    sealed;
	logic                  seal_store;

	assign accept   = rx_valid && rx_ready;
	assign rx_ready = !res_valid_q || res_ready;

	assign is_blank = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB);
	assign is_trim  = is_blank || (rx_byte == CH_CR);
	assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);

	assign acc_x10   = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {32'd0, rx_byte[3:0]};
	assign field_max = (idx_q < 3'd2) ? PCT_MAX : SECS_MAX;

	// Source word candidates after this byte; index 0 when entering the word
	always_comb begin
		logic [2:0] wi;
		logic [1:0] wg;
		wi = (phase_q == PH_SRC_WS) ? 3'd0 : idx_q;
		wg = (phase_q == PH_SRC_WS) ? 2'b11 : guess_q;
		if (rx_byte != src_a_char(wi))
			wg = wg & 2'b10;
		if (rx_byte != src_b_char(wi))
			wg = wg & 2'b01;
		wc_guess = wg;
	end

	// Phase after end of content (NUL or newline)
	always_comb begin
		seal_store = 1'b0;
		unique case (phase_q)
			PH_START, PH_LEAD_CR: sealed = PH_END_NONE;
			PH_PING_OK:           sealed = PH_END_PING;
			PH_HELLO_OK:          sealed = PH_END_HELLO;
			PH_NUM: begin
				if (idx_q >= 3'd3) begin
					sealed     = PH_DONE;
					seal_store = 1'b1;
				end else begin
					sealed = PH_BAD;
				end
			end
			PH_DONE, PH_BAD, PH_END_NONE, PH_END_PING, PH_END_HELLO: sealed = phase_q;
			default: sealed = PH_BAD;
		endcase
	end

	always_comb begin
		count_d = count_q;
		ovr_d   = ovr_q;
		phase_d = phase_q;
		idx_d   = idx_q;
		guess_d = guess_q;
		acc_d   = acc_q;
		p0_d    = p0_q;
		p1_d    = p1_q;
		s0_d    = s0_q;
		s1_d    = s1_q;

		res_load    = 1'b0;
		res_verdict = VERDICT_INVALID;
		res_source  = 1'b0;
		res_p0      = '0;
		res_p1      = '0;
		res_s0      = '0;
		res_s1      = '0;

		if (rx_byte == CH_LF) begin
			if (ovr_q) begin
				res_load    = 1'b1;
				res_verdict = VERDICT_OVERRUN;
			end else if (sealed != PH_END_NONE) begin
				res_load = 1'b1;
				priority case (sealed)
					PH_END_PING:  res_verdict = VERDICT_PING;
					PH_END_HELLO: res_verdict = VERDICT_HELLO;
					PH_DONE: begin
						res_verdict = VERDICT_RATE;
						res_source  = (guess_q == 2'b10);
						res_p0      = p0_q;
						res_p1      = p1_q;
						res_s0      = s0_q;
						res_s1      = seal_store ? acc_q : s1_q;
					end
					default: res_verdict = VERDICT_INVALID;
				endcase
			end
			count_d = '0;
			ovr_d   = 1'b0;
			phase_d = PH_START;
			idx_d   = '0;
			guess_d = 2'b11;
			acc_d   = '0;
		end else if (!ovr_q) begin
			if (count_q >= LINE_LIMIT) begin
				ovr_d = 1'b1;
			end else begin
				count_d = count_q + 1'b1;
				if (rx_byte == CH_NUL) begin
					phase_d = sealed;
					if (seal_store)
						s1_d = acc_q;
				end else begin
					unique case (phase_q)
						PH_START: begin
							if (!is_blank) begin
								idx_d = 3'd1;
								if (rx_byte == CH_CR)
									phase_d = PH_LEAD_CR;
								else if (rx_byte == CH_P)
									phase_d = PH_PING;
								else if (rx_byte == CH_H)
									phase_d = PH_HELLO;
								else if (rx_byte == CH_R)
									phase_d = PH_RATE_KW;
								else
									phase_d = PH_BAD;
							end
						end
						PH_LEAD_CR, PH_PING_OK, PH_HELLO_OK: begin
							if (!is_trim)
								phase_d = PH_BAD;
						end
						PH_PING: begin
							if (rx_byte == ping_char(idx_q)) begin
								idx_d = idx_q + 3'd1;
								if (idx_q == 3'd3)
									phase_d = PH_PING_OK;
							end else begin
								phase_d = PH_BAD;
							end
						end
						PH_HELLO: begin
							if (rx_byte == hello_char(idx_q)) begin
								idx_d = idx_q + 3'd1;
								if (idx_q == 3'd4)
									phase_d = PH_HELLO_OK;
							end else begin
								phase_d = PH_BAD;
							end
						end
						PH_RATE_KW: begin
							if (rx_byte == rate_char(idx_q)) begin
								idx_d = idx_q + 3'd1;
								if (idx_q == 3'd4)
									phase_d = PH_SRC_WS;
							end else begin
								phase_d = PH_BAD;
							end
						end
						PH_SRC_WS: begin
							if (!is_blank) begin
								guess_d = wc_guess;
								if (wc_guess == 2'b00) begin
									phase_d = PH_BAD;
								end else begin
									phase_d = PH_SRC_WORD;
									idx_d   = 3'd1;
								end
							end
						end
						PH_SRC_WORD: begin
							if (!is_blank) begin
								guess_d = wc_guess;
								if (wc_guess == 2'b00)
									phase_d = PH_BAD;
								else
									idx_d = idx_q + 3'd1;
							end else if (guess_q[0] && idx_q == 3'd5) begin
								guess_d = 2'b01;
								idx_d   = '0;
								phase_d = PH_NUM_WS;
							end else if (guess_q[1] && idx_q == 3'd6) begin
								guess_d = 2'b10;
								idx_d   = '0;
								phase_d = PH_NUM_WS;
							end else begin
								phase_d = PH_BAD;
							end
						end
						PH_NUM_WS: begin
							if (is_digit) begin
								acc_d   = {28'd0, rx_byte[3:0]};
								phase_d = PH_NUM;
							end else if (!is_blank) begin
								phase_d = PH_BAD;
							end
						end
						PH_NUM: begin
							if (is_digit) begin
								if (acc_x10 > {4'd0, field_max})
									phase_d = PH_BAD;
								else
									acc_d = acc_x10[31:0];
							end else begin
								unique case (idx_q[1:0])
									2'd0: p0_d = acc_q[6:0];
									2'd1: p1_d = acc_q[6:0];
									2'd2: s0_d = acc_q;
									2'd3: s1_d = acc_q;
								endcase
								if (idx_q >= 3'd3) begin
									phase_d = PH_DONE;
								end else begin
									idx_d   = idx_q + 3'd1;
									phase_d = is_blank ? PH_NUM_WS : PH_BAD;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovr_q   <= 1'b0;
			phase_q <= PH_START;
			idx_q   <= '0;
			guess_q <= 2'b11;
			acc_q   <= '0;
		end else if (accept) begin
			count_q <= count_d;
			ovr_q   <= ovr_d;
			phase_q <= phase_d;
			idx_q   <= idx_d;
			guess_q <= guess_d;
			acc_q   <= acc_d;
		end
	end

	// Field stores are always written before a line can reach the done phase
	always_ff @(posedge clk) begin
		if (accept) begin
			p0_q <= p0_d;
			p1_q <= p1_d;
			s0_q <= s0_d;
			s1_q <= s1_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept && res_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_load) begin
			verdict_q   <= res_verdict;
			source_q    <= res_source;
			pct_5h_q    <= res_p0;
			pct_week_q  <= res_p1;
			secs_5h_q   <= res_s0;
			secs_week_q <= res_s1;
		end
	end

	assign res_valid = res_valid_q;
	assign verdict   = verdict_q;
	assign source    = source_q;
	assign pct_5h    = pct_5h_q;
	assign pct_week  = pct_week_q;
	assign secs_5h   = secs_5h_q;
	assign secs_week = secs_week_q;

endmodule
